/* rtl/core/bhok_pkg.sv */
// ----------------------------------------------------------------------------
// bhok_pkg
// Shared types and constants of the BRIO round / Hilbert order key block.
// ----------------------------------------------------------------------------
package bhok_pkg;

  localparam int GRID_BITS    = 16;
  localparam int MAX_ROUNDS   = 24;
  localparam int NUM_STAGES   = 7;
  localparam int CURVE_STAGES = 4;
  localparam int ADDR_W       = 5;

  localparam logic [63:0] MIX_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL1  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL2  = 64'h94D0_49BB_1331_11EB;

  localparam logic [2:0] REG_ROUND_COUNT = 3'd0;
  localparam logic [2:0] REG_X_MIN       = 3'd1;
  localparam logic [2:0] REG_Y_MIN       = 3'd2;
  localparam logic [2:0] REG_X_SCALE     = 3'd3;
  localparam logic [2:0] REG_Y_SCALE     = 3'd4;

  typedef struct packed {
    logic        [31:0] point_index;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
  } in_beat_t;

  typedef struct packed {
    logic [4:0]  round_number;
    logic [31:0] hilbert_key;
    logic [31:0] index_echo;
  } out_beat_t;

  typedef struct packed {
    logic        [4:0]  round_count;
    logic signed [31:0] x_min;
    logic signed [31:0] y_min;
    logic        [31:0] x_scale;
    logic        [31:0] y_scale;
  } cfg_t;

endpackage

/* rtl/core/brio_hilbert_order_key.sv */
// ----------------------------------------------------------------------------
// brio_hilbert_order_key
// Per-point sort key: BRIO round from the index hash, Hilbert index of the
// quantized coordinates, index passed through.
// ----------------------------------------------------------------------------
//   channel  signals                          role
//   point    point_valid / point_stall / point  input beat: index, x, y
//   key      key_valid / key_stall / key        output beat: round, key, index
//   cfg      psel penable pwrite paddr pwdata   APB register writes and reads
//
// One beat per cycle while key is not stalled; key_valid is the valid bit of the last stage.
// The depth is set by the two 64-bit mixer multiplies, each split into
// 32-bit partial products and a summing stage, and by four Hilbert stages.
// Reset clears all stage valid bits and sets the registers to their defaults.
// A stall on key freezes full stages; empty stages still fill, so point_stall
// rises only when all seven stages hold a beat.
// ----------------------------------------------------------------------------
module brio_hilbert_order_key #(
  parameter int GRID_BITS = bhok_pkg::GRID_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        point_valid,
  output logic                        point_stall,
  input  bhok_pkg::in_beat_t          point,
  output logic                        key_valid,
  input  logic                        key_stall,
  output bhok_pkg::out_beat_t         key,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bhok_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int NS = bhok_pkg::NUM_STAGES;

  bhok_pkg::cfg_t       cfg;
  logic [NS-1:0]        vld;
  logic [NS-1:0]        en;
  logic [GRID_BITS-1:0] qx, qy;
  logic [4:0]           round_number;
  logic [31:0]          hilbert_key;
  logic [31:0]          index_echo;

  always_comb begin
    en[NS-1] = !vld[NS-1] || !key_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= point_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign point_stall = !en[0];
  assign key_valid   = vld[NS-1];

  assign key.round_number = round_number;
  assign key.hilbert_key  = hilbert_key;
  assign key.index_echo   = index_echo;

  bhok_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bhok_mix u_mix (
    .clk          (clk),
    .en           (en),
    .point_index  (point.point_index),
    .round_count  (cfg.round_count),
    .round_number (round_number),
    .index_echo   (index_echo)
  );

  bhok_quant #(.GRID_BITS(GRID_BITS)) u_quant (
    .clk     (clk),
    .en      (en[2:0]),
    .x_coord (point.x_coord),
    .y_coord (point.y_coord),
    .cfg     (cfg),
    .qx      (qx),
    .qy      (qy)
  );

  bhok_curve #(.GRID_BITS(GRID_BITS)) u_curve (
    .clk         (clk),
    .en          (en[NS-1:3]),
    .qx          (qx),
    .qy          (qy),
    .hilbert_key (hilbert_key)
  );

endmodule

/* rtl/core/bhok_regs.sv */
// ----------------------------------------------------------------------------
// bhok_regs
// APB register file: round count, bounding box minimum and Q16.16 scales.
// ----------------------------------------------------------------------------
module bhok_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bhok_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output bhok_pkg::cfg_t              cfg
);

  logic       wr;
  logic [2:0] sel;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign sel    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.round_count <= 5'd1;
      cfg.x_min       <= '0;
      cfg.y_min       <= '0;
      cfg.x_scale     <= '0;
      cfg.y_scale     <= '0;
    end else if (wr) begin
      case (sel)
        bhok_pkg::REG_ROUND_COUNT: cfg.round_count <= pwdata[4:0];
        bhok_pkg::REG_X_MIN:       cfg.x_min       <= pwdata;
        bhok_pkg::REG_Y_MIN:       cfg.y_min       <= pwdata;
        bhok_pkg::REG_X_SCALE:     cfg.x_scale     <= pwdata;
        bhok_pkg::REG_Y_SCALE:     cfg.y_scale     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      bhok_pkg::REG_ROUND_COUNT: prdata = {27'b0, cfg.round_count};
      bhok_pkg::REG_X_MIN:       prdata = cfg.x_min;
      bhok_pkg::REG_Y_MIN:       prdata = cfg.y_min;
      bhok_pkg::REG_X_SCALE:     prdata = cfg.x_scale;
      bhok_pkg::REG_Y_SCALE:     prdata = cfg.y_scale;
      default:                   prdata = '0;
    endcase
  end

endmodule

/* rtl/core/bhok_mix.sv */
// ----------------------------------------------------------------------------
// bhok_mix
// Index hash pipeline: 64-bit mixer in partial products, trailing zero count,
// round selection; carries the index alongside.
// ----------------------------------------------------------------------------
module bhok_mix (
  input  logic                              clk,
  input  logic [bhok_pkg::NUM_STAGES-1:0]   en,
  input  logic [31:0]                       point_index,
  input  logic [4:0]                        round_count,
  output logic [4:0]                        round_number,
  output logic [31:0]                       index_echo
);

  logic [63:0] z1, z2, z3;
  logic [63:0] h1, h2, h3;
  logic [63:0] pa0, pb0;
  logic [31:0] pa1, pa2, pb1, pb2;
  logic [6:0]  tz;
  logic [4:0]  rc, rm1;
  logic [4:0]  round_next;
  logic [31:0] echo [bhok_pkg::NUM_STAGES];

  function automatic logic [6:0] ctz64(input logic [63:0] h);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 63; i >= 0; i--) begin
      if (h[i]) n = 7'(i);
    end
    return n;
  endfunction

  assign z1 = {32'b0, point_index} + bhok_pkg::MIX_GAMMA;
  assign z2 = pa0 + {pa1 + pa2, 32'b0};
  assign z3 = pb0 + {pb1 + pb2, 32'b0};

  always_comb begin
    rc = round_count;
    if (rc == 5'd0) rc = 5'd1;
    if ({1'b0, round_count} > 6'(bhok_pkg::MAX_ROUNDS)) rc = 5'(bhok_pkg::MAX_ROUNDS);
    rm1 = rc - 5'd1;
    if (tz >= {2'b0, rm1}) round_next = 5'd0;
    else round_next = rm1 - tz[4:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) h1 <= z1 ^ (z1 >> 30);
    if (en[1]) begin
      pa0 <= h1[31:0] * bhok_pkg::MIX_MUL1[31:0];
      pa1 <= h1[31:0] * bhok_pkg::MIX_MUL1[63:32];
      pa2 <= h1[63:32] * bhok_pkg::MIX_MUL1[31:0];
    end
    if (en[2]) h2 <= z2 ^ (z2 >> 27);
    if (en[3]) begin
      pb0 <= h2[31:0] * bhok_pkg::MIX_MUL2[31:0];
      pb1 <= h2[31:0] * bhok_pkg::MIX_MUL2[63:32];
      pb2 <= h2[63:32] * bhok_pkg::MIX_MUL2[31:0];
    end
    if (en[4]) h3 <= z3 ^ (z3 >> 31);
    if (en[5]) tz <= ctz64(h3);
    if (en[6]) round_number <= round_next;
  end

  always_ff @(posedge clk) begin
    if (en[0]) echo[0] <= point_index;
    for (int k = 1; k < bhok_pkg::NUM_STAGES; k++) begin
      if (en[k]) echo[k] <= echo[k-1];
    end
  end

  assign index_echo = echo[bhok_pkg::NUM_STAGES-1];

endmodule

/* rtl/core/bhok_quant.sv */
// ----------------------------------------------------------------------------
// bhok_quant
// Coordinate quantizer, one lane per axis: offset, Q16.16 scale, clamp.
// ----------------------------------------------------------------------------
module bhok_quant #(
  parameter int GRID_BITS = bhok_pkg::GRID_BITS
) (
  input  logic                  clk,
  input  logic [2:0]            en,
  input  logic signed [31:0]    x_coord,
  input  logic signed [31:0]    y_coord,
  input  bhok_pkg::cfg_t        cfg,
  output logic [GRID_BITS-1:0]  qx,
  output logic [GRID_BITS-1:0]  qy
);

  localparam logic [GRID_BITS-1:0] QMAX = '1;

  logic signed [31:0]    coord [2];
  logic signed [31:0]    lo    [2];
  logic        [31:0]    scale [2];
  logic        [GRID_BITS-1:0] q [2];

  assign coord[0] = x_coord;
  assign coord[1] = y_coord;
  assign lo[0]    = cfg.x_min;
  assign lo[1]    = cfg.y_min;
  assign scale[0] = cfg.x_scale;
  assign scale[1] = cfg.y_scale;
  assign qx       = q[0];
  assign qy       = q[1];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [32:0] diff;
    logic [47:0] t;
    logic [31:0] mag;
    logic        pos;
    logic [63:0] prod;
    logic        pos2;
    logic [GRID_BITS-1:0] q_next;

    assign diff = {coord[l][31], coord[l]} - {lo[l][31], lo[l]};
    assign t    = prod[63:16];

    always_comb begin
      if (!pos2) q_next = '0;
      else if (t >= 48'(QMAX)) q_next = QMAX;
      else q_next = t[GRID_BITS-1:0];
    end

    always_ff @(posedge clk) begin
      if (en[0]) begin
        mag <= diff[31:0];
        pos <= !diff[32] && (diff != 33'd0) && (scale[l] != 32'd0);
      end
      if (en[1]) begin
        prod <= mag * scale[l];
        pos2 <= pos;
      end
      if (en[2]) q[l] <= q_next;
    end
  end

endmodule

/* rtl/core/bhok_curve.sv */
// ----------------------------------------------------------------------------
// bhok_curve
// Hilbert index pipeline: a few curve levels per stage, top level first.
// ----------------------------------------------------------------------------
module bhok_curve #(
  parameter int GRID_BITS = bhok_pkg::GRID_BITS
) (
  input  logic                                clk,
  input  logic [bhok_pkg::CURVE_STAGES-1:0]   en,
  input  logic [GRID_BITS-1:0]                qx,
  input  logic [GRID_BITS-1:0]                qy,
  output logic [31:0]                         hilbert_key
);

  localparam int NS  = bhok_pkg::CURVE_STAGES;
  localparam int SPS = (GRID_BITS + NS - 1) / NS;
  localparam int DW  = 2 * GRID_BITS;

  logic [GRID_BITS-1:0] xs [NS];
  logic [GRID_BITS-1:0] ys [NS];
  logic [DW-1:0]        ds [NS];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [GRID_BITS-1:0] xin, yin, xn, yn;
    logic [DW-1:0]        din, dn;

    if (g == 0) begin : g_first
      assign xin = qx;
      assign yin = qy;
      assign din = '0;
    end else begin : g_next
      assign xin = xs[g-1];
      assign yin = ys[g-1];
      assign din = ds[g-1];
    end

    always_comb begin
      logic [GRID_BITS-1:0] mask, tmp;
      logic                 bx, by;
      int                   b;
      xn   = xin;
      yn   = yin;
      dn   = din;
      mask = '0;
      tmp  = '0;
      bx   = 1'b0;
      by   = 1'b0;
      b    = 0;
      for (int j = 0; j < SPS; j++) begin
        if (g * SPS + j < GRID_BITS) begin
          b  = GRID_BITS - 1 - (g * SPS + j);
          bx = xn[b];
          by = yn[b];
          dn[2*b +: 2] = {bx, bx ^ by};
          if (!by) begin
            mask = GRID_BITS'((1 << b) - 1);
            if (bx) begin
              xn = xn ^ mask;
              yn = yn ^ mask;
            end
            tmp = xn;
            xn  = yn;
            yn  = tmp;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        xs[g] <= xn;
        ys[g] <= yn;
        ds[g] <= dn;
      end
    end
  end

  assign hilbert_key = 32'(ds[NS-1]);

endmodule

/* rtl/core/bhok_checker.sv */
// ----------------------------------------------------------------------------
// bhok_checker
// Port-level checks of the order key block, bound to its top level.
// ----------------------------------------------------------------------------
module bhok_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        point_stall,
  input bhok_pkg::out_beat_t         key,
  input logic                        key_valid,
  input logic                        key_stall
);

  // hold a stalled output beat
  a_key_hold: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_stall |=> key_valid && $stable(key))
    else $error("stalled key beat changed");

  a_no_backpressure: assert property (@(posedge clk) disable iff (rst)
    !key_stall |-> !point_stall)
    else $error("input stalled while output drains");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    key_valid |-> key.round_number <= 5'(bhok_pkg::MAX_ROUNDS - 1))
    else $error("round number beyond last round");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !key_valid)
    else $error("key beat right after reset");

endmodule

bind brio_hilbert_order_key bhok_checker u_bhok_checker (
  .clk         (clk),
  .rst         (rst),
  .point_stall (point_stall),
  .key         (key),
  .key_valid   (key_valid),
  .key_stall   (key_stall)
);
